>>> hw/rtl/emst_pkg.sv
// Shared types and constants for the Euclidean minimum spanning tree block.
// Used by the channel interfaces, the top level and the testbench.
package emst_pkg;

  localparam int unsigned CoordW = 20;
  localparam int unsigned IdW    = 16;
  localparam int unsigned EdgeNw = 6;
  localparam int unsigned DistW  = 41;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_ROW,
    S_SCAN,
    S_DRAIN,
    S_IDA,
    S_IDB,
    S_OUT,
    S_RELAB,
    S_RDRAIN
  } emst_state_t;

endpackage

>>> hw/rtl/emst_in_if.sv
// Point request channel: valid/ready handshake with one point as payload.
// Depends on emst_pkg for the field widths.
interface emst_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [emst_pkg::CoordW-1:0]        point_x;
  logic signed [emst_pkg::CoordW-1:0]        point_y;
  logic        [emst_pkg::IdW-1:0]           point_id;
  logic                                      last_point;

  modport source (output valid, point_x, point_y, point_id, last_point, input ready);
  modport sink (input valid, point_x, point_y, point_id, last_point, output ready);
endinterface

>>> hw/rtl/emst_out_if.sv
// Edge request channel: valid/ready handshake with one tree edge as payload.
// Depends on emst_pkg for the field widths.
interface emst_out_if;
  logic                              valid;
  logic                              ready;
  logic [emst_pkg::IdW-1:0]          end_a_id;
  logic [emst_pkg::IdW-1:0]          end_b_id;
  logic [emst_pkg::EdgeNw-1:0]       edge_number;
  logic [emst_pkg::DistW-1:0]        dist_sq;
  logic                              last_edge;

  modport source (output valid, end_a_id, end_b_id, edge_number, dist_sq, last_edge,
                  input ready);
  modport sink (input valid, end_a_id, end_b_id, edge_number, dist_sq, last_edge,
                output ready);
endinterface

>>> hw/rtl/emst_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
// Standalone; used for the point store and the component labels.
module emst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

>>> hw/rtl/emst_dist_pipe.sv
// Three-stage pair distance pipeline: absolute differences, squares, then a
// running minimum over (distance, first index, second index). Standalone.
module emst_dist_pipe #(
  parameter int unsigned CoordBits = 20,
  parameter int unsigned IdxW      = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   v_in,
  input  logic [CoordBits-1:0]   xi,
  input  logic [CoordBits-1:0]   yi,
  input  logic [IdxW-1:0]        li,
  input  logic [CoordBits-1:0]   xj,
  input  logic [CoordBits-1:0]   yj,
  input  logic [IdxW-1:0]        lj,
  input  logic [IdxW-1:0]        idx_i,
  input  logic [IdxW-1:0]        idx_j,
  output logic                   busy,
  output logic                   best_found,
  output logic [2*CoordBits:0]   best_d,
  output logic [IdxW-1:0]        best_i,
  output logic [IdxW-1:0]        best_j,
  output logic [IdxW-1:0]        best_li,
  output logic [IdxW-1:0]        best_lj
);
  localparam int unsigned DW = 2 * CoordBits + 1;

  logic                   va;
  logic [CoordBits-1:0]   dx;
  logic [CoordBits-1:0]   dy;
  logic [IdxW-1:0]        a_i, a_j, a_li, a_lj;
  logic                   vb;
  logic [2*CoordBits-1:0] sx;
  logic [2*CoordBits-1:0] sy;
  logic [IdxW-1:0]        b_i, b_j, b_li, b_lj;
  logic signed [CoordBits:0] diff_x, diff_y;
  logic [DW-1:0]          dsum;

  assign diff_x = $signed({xj[CoordBits-1], xj}) - $signed({xi[CoordBits-1], xi});
  assign diff_y = $signed({yj[CoordBits-1], yj}) - $signed({yi[CoordBits-1], yi});
  assign dsum   = DW'(sx) + DW'(sy);
  assign busy   = va | vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      best_found <= 1'b0;
    end else begin
      va <= v_in && (li != lj);
      vb <= va;
      if (clear) begin
        best_found <= 1'b0;
      end else if (vb && (!best_found || dsum < best_d)) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dx   <= diff_x[CoordBits] ? CoordBits'(-diff_x) : CoordBits'(diff_x);
    dy   <= diff_y[CoordBits] ? CoordBits'(-diff_y) : CoordBits'(diff_y);
    a_i  <= idx_i;
    a_j  <= idx_j;
    a_li <= li;
    a_lj <= lj;
    sx   <= dx * dx;
    sy   <= dy * dy;
    b_i  <= a_i;
    b_j  <= a_j;
    b_li <= a_li;
    b_lj <= a_lj;
    if (vb && (!best_found || dsum < best_d) && !clear) begin
      best_d  <= dsum;
      best_i  <= b_i;
      best_j  <= b_j;
      best_li <= b_li;
      best_lj <= b_lj;
    end
  end

`ifndef ASSERT_OFF
  a_order: assert property (@(posedge clk) disable iff (rst)
    vb && !clear |-> b_i < b_j) else $error("pair indices out of order");
`endif
endmodule

>>> hw/rtl/euclidean_min_spanning_tree_top.sv
// Top level of the Euclidean minimum spanning tree block.
// Depends on emst_pkg, emst_in_if, emst_out_if, emst_ram and emst_dist_pipe.

// Points are taken one per cycle and stored in load order; the point flagged
// last closes the set. For n points the block then labels every point and,
// for each of the n-1 tree edges, scans all n(n-1)/2 pairs through the point
// and label memories, one pair per cycle plus one row fetch per row, drains
// the three-stage distance pipeline, fetches both ids, emits the edge and
// relabels the merged component. The pair scan is bound by the single read
// port of the point memory. While a set is being processed no point is taken.
module euclidean_min_spanning_tree_top #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 20,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic       clk,
  input  logic       rst,
  emst_in_if.sink    points,
  emst_out_if.source edges
);
  import emst_pkg::*;

  localparam int unsigned IW  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned IDS = (ID_BITS < IdW) ? ID_BITS : IdW;
  localparam int unsigned PW  = IDS + 2 * CB;
  localparam int unsigned DW  = 2 * CB + 1;

  emst_state_t state, state_next;

  logic [CW-1:0] held;
  logic [CW-1:0] n_reg;
  logic [CW-1:0] n_close;
  logic [IW-1:0] i, j, t, k, wt;
  logic [IW-1:0] last_idx, last_row;
  logic          cap, v1, wv;
  logic [IW-1:0] p1_i, p1_j;
  logic [CB-1:0] row_x, row_y;
  logic [IW-1:0] row_l;
  logic [IDS-1:0] a_id;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          pw_en;
  logic [PW-1:0] pw_data;
  logic [PW-1:0] pt_q;
  logic          lw_en;
  logic [IW-1:0] lw_addr, lw_data;
  logic [IW-1:0] lead_q;
  logic          accept;
  logic          out_load;
  logic          pipe_clear;

  logic          busy, best_found;
  logic [DW-1:0] best_d;
  logic [IW-1:0] best_i, best_j, best_li, best_lj;

  assign last_idx = IW'(n_reg - CW'(1));
  assign last_row = IW'(n_reg - CW'(2));
  assign accept   = points.valid && points.ready;
  assign n_close  = (held < CW'(MAX_POINTS)) ? held + CW'(1) : held;
  assign pw_data  = {IDS'(points.point_id), CB'(points.point_y),
                     CB'(points.point_x)};

  emst_ram #(.Width(PW), .Depth(MAX_POINTS), .AddrW(IW)) u_points (
    .clk, .wr_en(pw_en), .wr_addr(held[IW-1:0]), .wr_data(pw_data),
    .rd_en, .rd_addr, .rd_data(pt_q)
  );

  emst_ram #(.Width(IW), .Depth(MAX_POINTS), .AddrW(IW)) u_leaders (
    .clk, .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(lw_data),
    .rd_en, .rd_addr, .rd_data(lead_q)
  );

  emst_dist_pipe #(.CoordBits(CB), .IdxW(IW)) u_dist (
    .clk, .rst, .clear(pipe_clear), .v_in(v1),
    .xi(row_x), .yi(row_y), .li(row_l),
    .xj(pt_q[CB-1:0]), .yj(pt_q[2*CB-1:CB]), .lj(lead_q),
    .idx_i(p1_i), .idx_j(p1_j),
    .busy, .best_found, .best_d, .best_i, .best_j, .best_li, .best_lj
  );

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (accept && points.last_point && n_close >= CW'(2)) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        if (t == last_idx) begin
          state_next = S_ROW;
        end
      end
      S_ROW: state_next = S_SCAN;
      S_SCAN: begin
        if (j == last_idx) begin
          state_next = (i == last_row) ? S_DRAIN : S_ROW;
        end
      end
      S_DRAIN: begin
        if (!v1 && !busy) begin
          state_next = S_IDA;
        end
      end
      S_IDA: state_next = S_IDB;
      S_IDB: state_next = S_OUT;
      S_OUT: begin
        if (!edges.valid || edges.ready) begin
          state_next = S_RELAB;
        end
      end
      S_RELAB: begin
        if (t == last_idx) begin
          state_next = S_RDRAIN;
        end
      end
      S_RDRAIN: state_next = (k == last_row) ? S_LOAD : S_ROW;
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    points.ready = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = i;
    pw_en        = 1'b0;
    lw_en        = 1'b0;
    lw_addr      = t;
    lw_data      = t;
    out_load     = 1'b0;
    pipe_clear   = 1'b0;
    case (state)
      S_LOAD: begin
        points.ready = 1'b1;
        pw_en        = accept && (held < CW'(MAX_POINTS));
      end
      S_INIT: begin
        lw_en      = 1'b1;
        pipe_clear = 1'b1;
      end
      S_ROW: begin
        rd_en   = 1'b1;
        rd_addr = i;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = j;
      end
      S_IDA: begin
        rd_en   = 1'b1;
        rd_addr = best_i;
      end
      S_IDB: begin
        rd_en   = 1'b1;
        rd_addr = best_j;
      end
      S_OUT: out_load = !edges.valid || edges.ready;
      S_RELAB: begin
        rd_en   = 1'b1;
        rd_addr = t;
        lw_en   = wv && (lead_q == best_lj);
        lw_addr = wt;
        lw_data = best_li;
      end
      S_RDRAIN: begin
        lw_en      = wv && (lead_q == best_lj);
        lw_addr    = wt;
        lw_data    = best_li;
        pipe_clear = 1'b1;
      end
      default: begin
        points.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      held        <= '0;
      cap         <= 1'b0;
      v1          <= 1'b0;
      wv          <= 1'b0;
      edges.valid <= 1'b0;
    end else begin
      state <= state_next;
      cap   <= (state == S_ROW);
      v1    <= (state == S_SCAN);
      wv    <= (state == S_RELAB);
      if (accept) begin
        if (points.last_point) begin
          held <= '0;
        end else if (held < CW'(MAX_POINTS)) begin
          held <= held + CW'(1);
        end
      end
      if (out_load) begin
        edges.valid <= 1'b1;
      end else if (edges.ready) begin
        edges.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_i <= i;
    p1_j <= j;
    wt   <= t;
    if (cap) begin
      row_x <= pt_q[CB-1:0];
      row_y <= pt_q[2*CB-1:CB];
      row_l <= lead_q;
    end
    case (state)
      S_LOAD: begin
        n_reg <= n_close;
        t     <= '0;
        i     <= '0;
        k     <= '0;
      end
      S_INIT: begin
        t <= t + IW'(1);
      end
      S_ROW: begin
        j <= i + IW'(1);
      end
      S_SCAN: begin
        if (j == last_idx) begin
          i <= i + IW'(1);
        end else begin
          j <= j + IW'(1);
        end
      end
      S_IDB: begin
        a_id <= pt_q[PW-1:2*CB];
        t    <= '0;
      end
      S_OUT: begin
        if (out_load) begin
          edges.end_a_id    <= IdW'(a_id);
          edges.end_b_id    <= IdW'(pt_q[PW-1:2*CB]);
          edges.edge_number <= EdgeNw'(k);
          edges.dist_sq     <= DistW'(best_d);
          edges.last_edge   <= (k == last_row);
        end
      end
      S_RELAB: begin
        t <= t + IW'(1);
      end
      S_RDRAIN: begin
        k <= k + IW'(1);
        i <= '0;
      end
      default: begin
        t <= t;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_found: assert property (@(posedge clk) disable iff (rst)
    state == S_IDA |-> best_found && best_i < best_j) else $error("no edge found");
  a_merge: assert property (@(posedge clk) disable iff (rst)
    state == S_RELAB |-> best_li != best_lj) else $error("merge within one component");
  a_held: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(MAX_POINTS)) else $error("point count overflow");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_LOAD |-> !points.ready) else $error("point taken while busy");
`endif
endmodule

>>> bench/emst_test_if.sv
`timescale 1ns / 100ps
// Bench-side package holding the point limit MaxPts; the RTL interfaces are reused as is.
// Does not depend on emst_pkg or on the RTL interfaces.
package emst_test_pkg;
  localparam int unsigned MaxPts = 64;
endpackage

>>> bench/emst_tree_checker.sv
`timescale 1ns / 100ps
// Checker for the spanning tree block: watches the point and edge channels,
// predicts each tree edge in Kruskal order and compares field by field.
module emst_tree_checker (
  input  logic        clk,
  input  logic        rst,
  emst_in_if          points,
  emst_out_if         edges,
  output int          errors,
  output int          pending
);
  import emst_pkg::*;
  import emst_test_pkg::*;

  typedef struct packed {
    logic [IdW-1:0]    a_id;
    logic [IdW-1:0]    b_id;
    logic [EdgeNw-1:0] num;
    logic [DistW-1:0]  sq;
    logic              last;
  } tree_edge_t;

  tree_edge_t edge_queue[$];
  logic signed [CoordW-1:0] px[MaxPts];
  logic signed [CoordW-1:0] py[MaxPts];
  logic [IdW-1:0] pid[MaxPts];
  int held;

  assign pending = edge_queue.size();

  function automatic logic [DistW-1:0] sq_dist(int i, int j);
    longint dx, dy;
    dx = longint'(px[i]) - longint'(px[j]);
    dy = longint'(py[i]) - longint'(py[j]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return DistW'(dx * dx + dy * dy);
  endfunction

  task automatic build_tree(int n);
    int leader[MaxPts];
    int bi, bj, from;
    logic [DistW-1:0] bd, d;
    bit found;
    tree_edge_t e;
    for (int i = 0; i < n; i++) leader[i] = i;
    for (int k = 0; k + 1 < n; k++) begin
      found = 0;
      bd = '0;
      bi = 0;
      bj = 0;
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (leader[i] != leader[j]) begin
            d = sq_dist(i, j);
            if (!found || d < bd) begin
              found = 1;
              bd = d;
              bi = i;
              bj = j;
            end
          end
        end
      end
      e.a_id = pid[bi];
      e.b_id = pid[bj];
      e.num = EdgeNw'(k);
      e.sq = bd;
      e.last = (k + 2 == n);
      edge_queue = {edge_queue, e};
      from = leader[bj];
      for (int t = 0; t < n; t++) if (leader[t] == from) leader[t] = leader[bi];
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held <= 0;
      errors <= 0;
    end else begin
      if (points.valid && points.ready) begin
        int n;
        n = held;
        if (n < int'(MaxPts)) begin
          px[n] = points.point_x;
          py[n] = points.point_y;
          pid[n] = points.point_id;
          n++;
        end
        if (points.last_point) begin
          if (n >= 2) build_tree(n);
          n = 0;
        end
        held <= n;
      end
      if (edges.valid && edges.ready) begin
        tree_edge_t got, want;
        got = {edges.end_a_id, edges.end_b_id, edges.edge_number, edges.dist_sq,
               edges.last_edge};
        if (edge_queue.size() == 0) begin
          $display("%0t: unexpected edge %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = edge_queue.pop_front();
          if (got !== want) begin
            $display("%0t: edge mismatch expected a=%h b=%h n=%0d d=%h l=%b",
                     $time, want.a_id, want.b_id, want.num, want.sq, want.last);
            $display("%0t:                  actual a=%h b=%h n=%0d d=%h l=%b",
                     $time, got.a_id, got.b_id, got.num, got.sq, got.last);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/euclidean_min_spanning_tree_top_test.sv
`timescale 1ns / 100ps
// Top of the spanning tree testbench: makes point sets and edge back-pressure,
// and gives the verdict. Depends on emst_pkg, the channel interfaces and the checker.
module euclidean_min_spanning_tree_top_test;
  import emst_pkg::*;

  logic clk;
  logic rst;
  int errors;
  int pending;
  int cycles;
  int sent;
  bit long_hold;
  bit finished;

  emst_in_if points ();
  emst_out_if edges ();

  euclidean_min_spanning_tree_top uut (
    .clk(clk), .rst(rst), .points(points.sink), .edges(edges.source)
  );

  emst_tree_checker tree_check (
    .clk(clk), .rst(rst), .points(points), .edges(edges),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                            logic [IdW-1:0] id, logic last);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6));
    if (gap != 0) begin
      points.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points.valid <= 1'b1;
    points.point_x <= x;
    points.point_y <= y;
    points.point_id <= id;
    points.last_point <= last;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_set(int n, int span);
    logic [CoordW-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (span == 0) begin
        x = CoordW'($urandom);
        y = CoordW'($urandom);
      end else begin
        x = CoordW'(int'($urandom_range(0, 2 * span)) - span);
        y = CoordW'(int'($urandom_range(0, 2 * span)) - span);
      end
      send_point(x, y, IdW'($urandom), i == n - 1);
    end
  endtask

  task automatic wait_idle();
    points.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int last_flag;
    rst = 1'b1;
    sent = 0;
    long_hold = 0;
    finished = 0;
    points.valid = 1'b0;
    points.point_x = '0;
    points.point_y = '0;
    points.point_id = '0;
    points.last_point = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_point(20'h80000, 20'h80000, 16'h0000, 1'b0);
    send_point(20'h7FFFF, 20'h7FFFF, 16'hFFFF, 1'b1);
    send_point(20'h00005, 20'h00007, 16'h1234, 1'b1);
    send_point(20'h00001, 20'h00001, 16'h0001, 1'b0);
    send_point(20'h00001, 20'h00001, 16'h0002, 1'b0);
    send_point(20'h00000, 20'h00000, 16'h0003, 1'b0);
    send_point(20'h00002, 20'h00002, 16'h0004, 1'b1);
    send_point(20'h00000, 20'h00000, 16'hAAAA, 1'b0);
    send_point(20'h00003, 20'h00000, 16'h5555, 1'b0);
    send_point(20'h00000, 20'h00004, 16'h0F0F, 1'b0);
    send_point(20'h80000, 20'h7FFFF, 16'hF0F0, 1'b1);
    wait_idle();
    send_set(64, 8);
    send_point(20'h00011, 20'h00022, 16'h0042, 1'b0);
    send_point(20'h00033, 20'h00044, 16'h0043, 1'b1);
    wait_idle();
    long_hold = 1;
    send_set(4, 3);
    send_set(5, 1000);
    wait_idle();
    while (sent < 480) begin
      last_flag = int'($urandom_range(0, 9));
      if (last_flag == 0) send_set(1, 0);
      else if (last_flag == 1) send_set(int'($urandom_range(10, 20)), 0);
      else send_set(int'($urandom_range(2, 8)), $urandom_range(0, 1) ? 0 : 4);
    end
    wait_idle();
    finished = 1;
  end

  initial begin
    int hold;
    edges.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        edges.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      hold = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 6));
      if (hold != 0) begin
        edges.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      edges.ready <= 1'b1;
      @(posedge clk);
      while (!edges.valid) @(posedge clk);
    end
  end

  initial begin
    wait (finished);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
